// ----- design/abim_pkg.sv -----
package abim_pkg;

    // Command codes as they arrive on the input channel
    localparam logic [2:0] CMD_SAMPLE      = 3'd0;
    localparam logic [2:0] CMD_CLEAR_LATCH = 3'd1;
    localparam logic [2:0] CMD_RESTART     = 3'd2;
    localparam logic [2:0] CMD_RESUME      = 3'd3;
    localparam logic [2:0] CMD_RESET_STATS = 3'd4;
    localparam logic [2:0] CMD_READ        = 3'd5;

    // Register indexes on the configuration port (byte address / 4)
    localparam logic [1:0] REG_SAMPLE_INTERVAL = 2'd0;
    localparam logic [1:0] REG_IDLE_THRESHOLD  = 2'd1;
    localparam logic [1:0] REG_BUFFER_ENABLE   = 2'd2;

    localparam logic [15:0] SAMPLE_INTERVAL_RST = 16'd100;

    localparam int RING_DEPTH_DEF = 256;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [31:0] WINDOW_MS   = 32'd1000;
    localparam logic [15:0] PULSE_CLAMP = 16'hFFFF;

    // now_ms / 1000 == (now_ms * SEC_RECIP) >> SEC_SHIFT for every 32-bit now_ms
    localparam logic [28:0] SEC_RECIP = 29'd274877907;
    localparam int          SEC_SHIFT = 38;
    localparam int          PROD_W    = 61;

    typedef enum logic [2:0] {
        KIND_SAMPLE,
        KIND_CLEAR_LATCH,
        KIND_RESTART,
        KIND_RESUME,
        KIND_RESET_STATS,
        KIND_READ,
        KIND_NOP
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] now_ms;
        logic [14:0] pulse_count;
        logic [7:0]  entry_index;
        logic [22:0] now_sec;
    } item_t;

    typedef struct packed {
        logic [15:0] min_gap_ms;
        logic        buffer_enabled;
        logic        ring_clear;
    } cfg_t;

    typedef struct packed {
        logic        busy_res;
        logic        activity_latch;
        logic [31:0] idle_ms;
        logic [31:0] longest_idle_ms;
        logic [31:0] active_seconds;
        logic [31:0] idle_seconds;
        logic        entry_valid;
        logic [22:0] entry_second;
        logic [15:0] entry_pulses;
        logic [8:0]  ring_fill;
        logic [7:0]  ring_head;
    } res_t;

endpackage

// ----- design/abim_front.sv -----
module abim_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [55:0]        s_tdata,
    input  logic [2:0]         s_tuser,
    output logic               f_valid,
    input  logic               f_ready,
    output abim_pkg::item_t    f_item
);
    import abim_pkg::*;

    logic              valid_reg;
    kind_t             kind_reg;
    kind_t             kind_next;
    logic [31:0]       now_reg;
    logic [14:0]       pulse_reg;
    logic [7:0]        index_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic              s_fire;

    assign s_tready = !valid_reg || f_ready;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        case (s_tuser)
            CMD_SAMPLE:      kind_next = KIND_SAMPLE;
            CMD_CLEAR_LATCH: kind_next = KIND_CLEAR_LATCH;
            CMD_RESTART:     kind_next = KIND_RESTART;
            CMD_RESUME:      kind_next = KIND_RESUME;
            CMD_RESET_STATS: kind_next = KIND_RESET_STATS;
            CMD_READ:        kind_next = KIND_READ;
            default:         kind_next = KIND_NOP;
        endcase
        prod_next = PROD_W'(s_tdata[31:0]) * PROD_W'(SEC_RECIP);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_fire) begin
            valid_reg <= 1'b1;
        end else if (f_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            kind_reg  <= kind_next;
            now_reg   <= s_tdata[31:0];
            pulse_reg <= s_tdata[46:32];
            index_reg <= s_tdata[54:47];
            prod_reg  <= prod_next;
        end
    end

    assign f_valid             = valid_reg;
    assign f_item.kind         = kind_reg;
    assign f_item.now_ms       = now_reg;
    assign f_item.pulse_count  = pulse_reg;
    assign f_item.entry_index  = index_reg;
    assign f_item.now_sec      = prod_reg[PROD_W-1:SEC_SHIFT];

endmodule

// ----- design/abim_queue.sv -----
module abim_queue #(
    parameter int DEPTH = abim_pkg::QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    output logic               push_ready,
    input  abim_pkg::item_t    push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output abim_pkg::item_t    pop_item
);
    import abim_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t         slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          push;
    logic          pop;

    assign push_ready = count_reg != CW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("queue count above depth");
`endif

endmodule

// ----- design/abim_back.sv -----
module abim_back #(
    parameter int RING_DEPTH = abim_pkg::RING_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  abim_pkg::cfg_t     cfg,
    input  logic               q_valid,
    output logic               q_ready,
    input  abim_pkg::item_t    q_item,
    output logic               o_valid,
    input  logic               o_ready,
    output abim_pkg::res_t     o_res
);
    import abim_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam int FW = $clog2(RING_DEPTH + 1);
    localparam int IW = (FW > 8) ? FW : 8;
    localparam int EW = 23 + 16;

    // architectural state
    logic [31:0]   last_smp_reg,  last_smp_next;
    logic [31:0]   last_win_reg,  last_win_next;
    logic          busy_reg,      busy_next;
    logic          latch_reg,     latch_next;
    logic [31:0]   idle_reg,      idle_next;
    logic [31:0]   longest_reg,   longest_next;
    logic [31:0]   wsum_reg,      wsum_next;
    logic [31:0]   act_win_reg,   act_win_next;
    logic [31:0]   idle_win_reg,  idle_win_next;
    logic [AW-1:0] head_reg,      head_next;
    logic [FW-1:0] fill_reg,      fill_next;

    logic [EW-1:0] ring_mem [RING_DEPTH];
    logic [EW-1:0] rdata_reg;

    // result register
    logic          o_valid_reg;
    res_t          o_res_reg,     o_res_next;
    logic          o_rd_reg,      o_rd_next;

    logic          fire;
    logic [31:0]   elapsed;
    logic [31:0]   win_elapsed;
    logic          smp_ok;
    logic          win_close;
    logic [32:0]   idle_sum;
    logic [31:0]   idle_sat;
    logic [32:0]   wsum_sum;
    logic [31:0]   wsum_sat;
    logic [15:0]   win_pulses;
    logic [AW-1:0] head_inc;
    logic          wr_en;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          ev;
    logic [22:0]   esec;
    logic [15:0]   epul;

    assign fire    = q_valid && (!o_valid_reg || o_ready);
    assign q_ready = !o_valid_reg || o_ready;
    assign rd_addr = AW'(q_item.entry_index);

    always_comb begin
        elapsed     = q_item.now_ms - last_smp_reg;
        win_elapsed = q_item.now_ms - last_win_reg;
        smp_ok      = elapsed >= {16'b0, cfg.min_gap_ms};
        win_close   = win_elapsed >= WINDOW_MS;
        idle_sum    = {1'b0, idle_reg} + {1'b0, elapsed};
        idle_sat    = idle_sum[32] ? '1 : idle_sum[31:0];
        wsum_sum    = {1'b0, wsum_reg} + 33'(q_item.pulse_count);
        wsum_sat    = wsum_sum[32] ? '1 : wsum_sum[31:0];
        win_pulses  = (wsum_sat > {16'b0, PULSE_CLAMP}) ? PULSE_CLAMP : wsum_sat[15:0];
        head_inc    = (head_reg == AW'(RING_DEPTH - 1)) ? '0 : head_reg + 1'b1;

        last_smp_next = last_smp_reg;
        last_win_next = last_win_reg;
        busy_next     = busy_reg;
        latch_next    = latch_reg;
        idle_next     = idle_reg;
        longest_next  = longest_reg;
        wsum_next     = wsum_reg;
        act_win_next  = act_win_reg;
        idle_win_next = idle_win_reg;
        head_next     = head_reg;
        fill_next     = fill_reg;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        ev            = 1'b0;
        esec          = '0;
        epul          = '0;

        case (q_item.kind)
            KIND_SAMPLE: begin
                if (smp_ok) begin
                    last_smp_next = q_item.now_ms;
                    busy_next     = q_item.pulse_count != '0;
                    if (q_item.pulse_count != '0) begin
                        idle_next  = '0;
                        latch_next = 1'b1;
                    end else begin
                        idle_next = idle_sat;
                        if (idle_sat > longest_reg) begin
                            longest_next = idle_sat;
                        end
                    end
                    wsum_next = wsum_sat;
                    if (win_close) begin
                        ev   = 1'b1;
                        esec = q_item.now_sec;
                        epul = win_pulses;
                        if (cfg.buffer_enabled) begin
                            wr_en     = fire;
                            head_next = head_inc;
                            if (fill_reg != FW'(RING_DEPTH)) begin
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                        if (wsum_sat != '0) begin
                            act_win_next = (act_win_reg == '1) ? '1 : act_win_reg + 1'b1;
                        end else begin
                            idle_win_next = (idle_win_reg == '1) ? '1 : idle_win_reg + 1'b1;
                        end
                        wsum_next     = '0;
                        last_win_next = q_item.now_ms;
                    end
                end
            end
            KIND_CLEAR_LATCH: begin
                latch_next = 1'b0;
                busy_next  = 1'b0;
            end
            KIND_RESTART: begin
                idle_next     = '0;
                last_smp_next = q_item.now_ms;
                last_win_next = q_item.now_ms;
                wsum_next     = '0;
                if (q_item.pulse_count != '0) begin
                    latch_next = 1'b1;
                end
            end
            KIND_RESUME: begin
                last_smp_next = q_item.now_ms;
                last_win_next = q_item.now_ms;
                wsum_next     = '0;
            end
            KIND_RESET_STATS: begin
                longest_next  = '0;
                act_win_next  = '0;
                idle_win_next = '0;
                head_next     = '0;
                fill_next     = '0;
                wsum_next     = '0;
                last_win_next = q_item.now_ms;
            end
            KIND_READ: begin
                if (IW'(q_item.entry_index) < IW'(RING_DEPTH) &&
                    IW'(q_item.entry_index) < IW'(fill_reg)) begin
                    ev    = 1'b1;
                    rd_en = fire;
                end
            end
            default: begin
            end
        endcase

        o_rd_next                  = rd_en;
        o_res_next.busy_res        = busy_next;
        o_res_next.activity_latch  = latch_next;
        o_res_next.idle_ms         = idle_next;
        o_res_next.longest_idle_ms = longest_next;
        o_res_next.active_seconds  = act_win_next;
        o_res_next.idle_seconds    = idle_win_next;
        o_res_next.entry_valid     = ev;
        o_res_next.entry_second    = esec;
        o_res_next.entry_pulses    = epul;
        o_res_next.ring_fill       = 9'(fill_next);
        o_res_next.ring_head       = 8'(head_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_smp_reg <= '0;
            last_win_reg <= '0;
            busy_reg     <= 1'b0;
            latch_reg    <= 1'b0;
            idle_reg     <= '0;
            longest_reg  <= '0;
            wsum_reg     <= '0;
            act_win_reg  <= '0;
            idle_win_reg <= '0;
            head_reg     <= '0;
            fill_reg     <= '0;
            o_valid_reg  <= 1'b0;
        end else begin
            if (fire) begin
                last_smp_reg <= last_smp_next;
                last_win_reg <= last_win_next;
                busy_reg     <= busy_next;
                latch_reg    <= latch_next;
                idle_reg     <= idle_next;
                longest_reg  <= longest_next;
                wsum_reg     <= wsum_next;
                act_win_reg  <= act_win_next;
                idle_win_reg <= idle_win_next;
                head_reg     <= head_next;
                fill_reg     <= fill_next;
            end
            // toggling the buffer empties the ring
            if (cfg.ring_clear) begin
                head_reg <= '0;
                fill_reg <= '0;
            end
            if (fire) begin
                o_valid_reg <= 1'b1;
            end else if (o_ready) begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            o_res_reg <= o_res_next;
            o_rd_reg  <= o_rd_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring_mem[head_reg] <= {q_item.now_sec, win_pulses};
        end
        if (rd_en) begin
            rdata_reg <= ring_mem[rd_addr];
        end
    end

    always_comb begin
        o_res = o_res_reg;
        if (o_rd_reg) begin
            o_res.entry_second = rdata_reg[EW-1:16];
            o_res.entry_pulses = rdata_reg[15:0];
        end
    end

    assign o_valid = o_valid_reg;

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FW'(RING_DEPTH))
        else $error("ring fill above depth");

    a_head_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg <= AW'(RING_DEPTH - 1))
        else $error("ring head out of range");

    a_stats_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && q_item.kind == KIND_RESET_STATS |=> fill_reg == '0 && act_win_reg == '0)
        else $error("statistics reset did not empty ring and counters");

    a_read_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        o_valid_reg && o_rd_reg |-> o_res_reg.entry_valid)
        else $error("ring read result without entry_valid");
`endif

endmodule

// ----- design/bus_activity_idle_monitor_top.sv -----
// Channel   Dir  Ports                        Contents
// s_        in   s_tvalid/s_tready            s_tdata: now_ms[31:0], pulse_count[46:32],
//                s_tdata[55:0], s_tuser[2:0]    entry_index[54:47]; s_tuser: command
// m_        out  m_tvalid/m_tready            one status result per input transfer
//                m_tdata[191:0]
// apb       in   psel/penable/pwrite/paddr    0x0 sample interval, 0x4 idle_threshold_ms,
//                pwdata/prdata/pready           0x8 buffer_enabled
//
// One transfer is taken and one result leaves per cycle while m_tready is high; the back
// end's state update sets that rate. A result passes the front register, a queue slot
// and the result register before it is offered.
// Reset (aresetn low, synchronous) clears counters, flags, ring head and fill; the ring
// memory keeps its contents and needs no clearing pass.
// m_tready low stalls only the back end; the queue absorbs transfers until full.
module bus_activity_idle_monitor_top #(
    parameter int RING_DEPTH  = abim_pkg::RING_DEPTH_DEF,
    parameter int QUEUE_DEPTH = abim_pkg::QUEUE_DEPTH
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [55:0]  s_tdata,   // now_ms[31:0], pulse_count[46:32], entry_index[54:47]
    input  logic [2:0]   s_tuser,   // command[2:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    // busy_res[0], activity_latch[1], idle_ms[33:2], longest_idle_ms[65:34],
    // idle_reached[66], active_seconds[98:67], idle_seconds[130:99], entry_valid[131],
    // entry_second[154:132], entry_pulses[170:155], ring_fill[179:171],
    // ring_head[187:180], zero[191:188]
    output logic [191:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import abim_pkg::*;

    logic [15:0] interval_reg;
    logic [31:0] threshold_reg;
    logic        buf_en_reg;
    logic        cfg_wr;
    logic [1:0]  reg_idx;
    cfg_t        cfg;

    logic        f_valid;
    logic        f_ready;
    item_t       f_item;
    logic        q_valid;
    logic        q_ready;
    item_t       q_item;
    res_t        res;

    // Configuration registers: write on the access phase, read combinationally
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg  <= SAMPLE_INTERVAL_RST;
            threshold_reg <= '0;
            buf_en_reg    <= 1'b0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_SAMPLE_INTERVAL: interval_reg  <= pwdata[15:0];
                REG_IDLE_THRESHOLD:  threshold_reg <= pwdata;
                REG_BUFFER_ENABLE:   buf_en_reg    <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SAMPLE_INTERVAL: prdata = {16'b0, interval_reg};
            REG_IDLE_THRESHOLD:  prdata = threshold_reg;
            REG_BUFFER_ENABLE:   prdata = {31'b0, buf_en_reg};
            default:             prdata = '0;
        endcase
    end

    // A write that flips buffer_enabled empties the ring in the same edge
    assign cfg.min_gap_ms     = interval_reg;
    assign cfg.buffer_enabled = buf_en_reg;
    assign cfg.ring_clear     = cfg_wr && reg_idx == REG_BUFFER_ENABLE &&
                                pwdata[0] != buf_en_reg;

    // Front: accept, decode the command, precompute the second stamp
    abim_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .f_valid  (f_valid),
        .f_ready  (f_ready),
        .f_item   (f_item)
    );

    // Queue: lets front and back stall independently
    abim_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    // Back: update idle and window statistics, run the ring, hold the result
    abim_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item),
        .o_valid (m_tvalid),
        .o_ready (m_tready),
        .o_res   (res)
    );

    // Pack the result; idle_reached is compared against the live threshold, which the user
    // must change only while no result is outstanding; the block does not enforce this
    assign m_tdata = {4'b0,
                      res.ring_head,
                      res.ring_fill,
                      res.entry_pulses,
                      res.entry_second,
                      res.entry_valid,
                      res.idle_seconds,
                      res.active_seconds,
                      res.idle_ms >= threshold_reg,
                      res.longest_idle_ms,
                      res.idle_ms,
                      res.activity_latch,
                      res.busy_res};

endmodule
